// ===== sv/ubs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubs_pkg: shared types and codes of the upper-bound search engine
// Field widths, function and status codes, sequencer states and the result
// record passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package ubs_pkg;

   localparam int DATA_W            = 32;
   localparam int IDX_W             = 11;
   localparam int FUNC_W            = 2;
   localparam int STAT_W            = 2;
   localparam int TABLE_DEPTH_DEF   = 1024;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_FIRST,
      ST_CHK_LAST,
      ST_CHK_MID,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0]  found_index;
      logic [STAT_W-1:0] status;
   } res_type;

endpackage

// ===== sv/ubs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubs_ram: single-port table memory
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
module ubs_ram #(
   parameter int TABLE_DEPTH = ubs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic                                 we,
   input  logic [$clog2(TABLE_DEPTH)-1:0]       addr,
   input  logic signed [ubs_pkg::DATA_W-1:0]    wdata,
   output logic signed [ubs_pkg::DATA_W-1:0]    rdata
);
   import ubs_pkg::*;

   logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ubs_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubs_seq: search sequencer
// Handles clear and append, and runs the end checks and bisection of a query
// through one comparator against the registered memory read data.
// ----------------------------------------------------------------------------
module ubs_seq #(
   parameter int TABLE_DEPTH = ubs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ubs_pkg::FUNC_W-1:0]           req_func,
   input  logic signed [ubs_pkg::DATA_W-1:0]    req_operand_value,
   output logic                                 res_valid,
   input  logic                                 res_take,
   output ubs_pkg::res_type                     res,
   output logic                                 ram_en,
   output logic                                 ram_we,
   output logic [$clog2(TABLE_DEPTH)-1:0]       ram_addr,
   output logic signed [ubs_pkg::DATA_W-1:0]    ram_wdata,
   input  logic signed [ubs_pkg::DATA_W-1:0]    ram_rdata
);
   import ubs_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [AW-1:0]            lo_ff, lo_in;
   logic [AW-1:0]            hi_ff, hi_in;
   logic [AW-1:0]            mid_ff, mid_in;
   res_type                  res_ff, res_in;

   logic                     probe_le;
   logic [CW-1:0]            count_m1;
   logic [AW-1:0]            last;
   logic [AW-1:0]            nlo, nhi, span, mid_nx;
   logic [AW:0]              bound_sum;
   logic                     go_on;
   logic [CW+IDX_W-1:0]      count_ext;
   logic [AW+IDX_W-1:0]      nhi_ext;

   // shared compare unit: every probe tests table[addr] <= key
   assign probe_le  = ram_rdata <= key_ff;
   assign count_m1  = count_ff - CW'(1);
   assign last      = count_m1[AW-1:0];
   assign count_ext = {{IDX_W{1'b0}}, count_ff};

   always_comb begin
      if (state_ff == ST_CHK_LAST) begin
         nlo = '0;
         nhi = last;
      end else begin
         nlo = probe_le ? mid_ff : lo_ff;
         nhi = probe_le ? hi_ff : mid_ff;
      end
   end

   assign span      = nhi - nlo;
   assign go_on     = span > AW'(1);
   assign bound_sum = {1'b0, nlo} + {1'b0, nhi};
   assign mid_nx    = bound_sum[AW:1];
   assign nhi_ext   = {{IDX_W{1'b0}}, nhi};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      key_ff <= key_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      res_in    = res_ff;
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = '0;
      ram_wdata = req_operand_value;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in   = req_operand_value;
               state_in = ST_RESP;
               res_in   = '{found_index: '0, status: STAT_OK};
               case (req_func)
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_APPEND: begin
                     if (count_ff < CW'(TABLE_DEPTH)) begin
                        ram_en   = 1'b1;
                        ram_we   = 1'b1;
                        ram_addr = count_ff[AW-1:0];
                        count_in = count_ff + CW'(1);
                     end else begin
                        res_in.status = STAT_FULL;
                     end
                  end
                  FUNC_QUERY: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        // probe the first entry
                        ram_en   = 1'b1;
                        state_in = ST_CHK_FIRST;
                     end
                  end
                  default: begin
                     res_in.status = STAT_OK;
                  end
               endcase
            end
         end
         ST_CHK_FIRST: begin
            if (!probe_le) begin
               res_in   = '{found_index: '0, status: STAT_OK};
               state_in = ST_RESP;
            end else begin
               ram_en   = 1'b1;
               ram_addr = last;
               state_in = ST_CHK_LAST;
            end
         end
         ST_CHK_LAST, ST_CHK_MID: begin
            if (state_ff == ST_CHK_LAST && probe_le) begin
               res_in   = '{found_index: count_ext[IDX_W-1:0], status: STAT_OK};
               state_in = ST_RESP;
            end else begin
               // narrow the bracket; issue the next midpoint probe or return its upper end
               lo_in = nlo;
               hi_in = nhi;
               if (go_on) begin
                  ram_en   = 1'b1;
                  ram_addr = mid_nx;
                  mid_in   = mid_nx;
                  state_in = ST_CHK_MID;
               end else begin
                  res_in   = '{found_index: nhi_ext[IDX_W-1:0], status: STAT_OK};
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;
   assign res_valid = state_ff == ST_RESP;
   assign res       = res_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_mid_inside: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHK_MID |-> (lo_ff < mid_ff) && (mid_ff < hi_ff))
      else $error("midpoint probe outside bracket");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ff.status == STAT_EMPTY |-> res_ff.found_index == '0)
      else $error("empty status with nonzero index");

   a_query_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && req_valid && req_func == FUNC_QUERY && count_ff != '0
      |=> state_ff == ST_CHK_FIRST)
      else $error("query on loaded table skipped first probe");
`endif

endmodule

// ===== sv/upper_bound_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upper_bound_search: sorted-table upper-bound search engine
// Top level: table memory, search sequencer and the result output register.
// ----------------------------------------------------------------------------
// A clear, an append or a query on an empty table goes from the transfer
// straight to its result. A query on a table of n entries, n of two or more,
// runs the first-entry check, the last-entry check and up to ceil(log2(n-1))
// bisection probes in turn; each probe is one registered read of the
// single-port table memory checked by one shared comparator. The result then
// loads the output register and waits there for its transfer. A key below the
// first entry returns after the first-entry check, a key at or above the last
// entry after the last-entry check. One item is in work at a time: req_stall
// is high from the transfer until the result moves into the output register,
// which may still hold the previous result while the next item is being
// searched.
module upper_bound_search #(
   parameter int TABLE_DEPTH = ubs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ubs_pkg::FUNC_W-1:0]           req_func,
   input  logic signed [ubs_pkg::DATA_W-1:0]    req_operand_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ubs_pkg::IDX_W-1:0]            rsp_found_index,
   output logic [ubs_pkg::STAT_W-1:0]           rsp_status
);
   import ubs_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   logic                     res_valid, res_take;
   res_type                  res;
   logic                     ram_en, ram_we;
   logic [AW-1:0]            ram_addr;
   logic signed [DATA_W-1:0] ram_wdata, ram_rdata;
   logic                     rsp_valid_ff, rsp_valid_in;
   res_type                  rsp_ff, rsp_in;

   ubs_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   ubs_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_operand_value (req_operand_value),
      .res_valid         (res_valid),
      .res_take          (res_take),
      .res               (res),
      .ram_en            (ram_en),
      .ram_we            (ram_we),
      .ram_addr          (ram_addr),
      .ram_wdata         (ram_wdata),
      .ram_rdata         (ram_rdata)
   );

   // load when the register is empty or its transfer completes this cycle
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_index = rsp_ff.found_index;
   assign rsp_status      = rsp_ff.status;

endmodule

// ===== tb/sv/tb_upper_bound_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_upper_bound_search: self-checking testbench of the upper-bound search
// A queue of table loads, clears and key lookups feeds a bursty driver. A
// monitor predicts every accepted transfer against its own copy of the table
// and compares each result, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_upper_bound_search;
   import ubs_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam longint VAL_MIN = -(64'sd1 <<< 31);
   localparam longint VAL_MAX = (64'sd1 <<< 31) - 1;
   localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
      bit                       drain;
   } search_req_type;

   typedef enum {RX_FLOW, RX_SPARSE, RX_TOGGLE, RX_HEAVY} rx_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func = FUNC_CLEAR;
   logic signed [DATA_W-1:0] req_operand_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [IDX_W-1:0]         rsp_found_index;
   logic [STAT_W-1:0]        rsp_status;

   // stimulus side
   search_req_type pending_reqs[$];
   int          loaded_vals[$];
   int          n_queued = 0;
   int          burst_left = 0;
   int          gap_left = 0;

   // receiver side
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   rx_mode_type rx_mode = RX_FLOW;
   int          mode_left = 0;

   // prediction and checking
   logic signed [DATA_W-1:0] shadow_table [0:DEPTH-1];
   int          shadow_count = 0;
   res_type     expected_results[$];
   int          outstanding = 0;
   int          results_seen = 0;
   int          fail_count = 0;

   upper_bound_search #(.TABLE_DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found_index   (rsp_found_index),
      .rsp_status        (rsp_status)
   );

   always #5 clock = ~clock;

   // Apply one transfer to the shadow table and return the result it must give.
   function automatic res_type search_result(input logic [FUNC_W-1:0] f,
                                             input logic signed [DATA_W-1:0] key);
      res_type r;
      int      lo;
      int      hi;
      int      mid;
      int      idx;
      r = '0;
      idx = 0;
      case (f)
         FUNC_CLEAR: begin
            shadow_count = 0;
         end
         FUNC_APPEND: begin
            if (shadow_count < DEPTH) begin
               shadow_table[shadow_count] = key;
               shadow_count++;
            end else begin
               r.status = STAT_FULL;
            end
         end
         FUNC_QUERY: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (key < shadow_table[0]) begin
               idx = 0;
            end else if (shadow_table[shadow_count-1] <= key) begin
               idx = shadow_count;
            end else begin
               // bisect with the same probe order, so unsorted tables match too
               lo = 0;
               hi = shadow_count - 1;
               while (hi - lo > 1) begin
                  mid = (lo + hi) / 2;
                  if (shadow_table[mid] <= key) lo = mid;
                  else hi = mid;
               end
               idx = hi;
            end
            r.found_index = idx[IDX_W-1:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_item(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
                             input bit drain);
      search_req_type it;
      it.func = f;
      it.value = v;
      it.drain = drain;
      pending_reqs.push_back(it);
      if (f != FUNC_UNUSED) n_queued++;
      // track table contents so keys can be aimed at real entries
      if (f == FUNC_CLEAR) loaded_vals.delete();
      else if (f == FUNC_APPEND && loaded_vals.size() < DEPTH) loaded_vals.push_back(int'(v));
   endtask

   task automatic queue_ascending(input int n, input int unsigned step_max);
      longint v;
      for (int i = 0; i < n; i++) begin
         if (loaded_vals.size() == 0)
            v = ($urandom_range(0, 5) == 0) ? VAL_MIN : longint'(int'($urandom));
         else
            v = longint'(loaded_vals[$]) + longint'($urandom_range(0, step_max));
         if (v > VAL_MAX) v = VAL_MAX;
         queue_item(FUNC_APPEND, v[DATA_W-1:0], 1'b0);
      end
   endtask

   function automatic logic signed [DATA_W-1:0] pick_key();
      longint k;
      int     n;
      n = loaded_vals.size();
      if (n == 0) return $urandom;
      case ($urandom_range(0, 7))
         0: k = loaded_vals[$urandom_range(0, n-1)];
         1: k = longint'(loaded_vals[$urandom_range(0, n-1)]) - 1;
         2: k = longint'(loaded_vals[$urandom_range(0, n-1)]) + 1;
         3: k = longint'(loaded_vals[0]) - longint'($urandom_range(1, 1000));
         4: k = longint'(loaded_vals[n-1]) + longint'($urandom_range(0, 1000));
         5: k = longint'(int'($urandom));
         6: k = VAL_MIN;
         default: k = VAL_MAX;
      endcase
      if (k < VAL_MIN) k = VAL_MIN;
      if (k > VAL_MAX) k = VAL_MAX;
      return k[DATA_W-1:0];
   endfunction

   function automatic int unsigned pick_step();
      case ($urandom_range(0, 3))
         0: return 3;
         1: return 1000;
         2: return 32'h0100_0000;
         default: return 32'h4000_0000;
      endcase
   endfunction

   initial begin
      int base;
      int sel;
      int unsigned step;

      // directed: empty table, unused selector, extremes, duplicates
      queue_item(FUNC_QUERY, 32'sd0, 1'b0);
      queue_item(FUNC_UNUSED, S_MIN, 1'b0);
      queue_item(FUNC_APPEND, S_MIN, 1'b0);
      queue_item(FUNC_APPEND, -32'sd5, 1'b0);
      queue_item(FUNC_APPEND, 32'sd0, 1'b0);
      queue_item(FUNC_APPEND, 32'sd0, 1'b0);
      queue_item(FUNC_APPEND, 32'sd7, 1'b0);
      queue_item(FUNC_APPEND, S_MAX, 1'b0);
      queue_item(FUNC_QUERY, S_MIN, 1'b0);
      queue_item(FUNC_QUERY, -32'sd6, 1'b0);
      queue_item(FUNC_QUERY, -32'sd5, 1'b0);
      queue_item(FUNC_QUERY, 32'sd0, 1'b0);
      queue_item(FUNC_QUERY, 32'sd6, 1'b0);
      queue_item(FUNC_QUERY, S_MAX, 1'b0);
      queue_item(FUNC_UNUSED, -32'sd1, 1'b0);
      queue_item(FUNC_QUERY, 32'sd7, 1'b0);
      queue_item(FUNC_CLEAR, S_MAX, 1'b0);
      queue_item(FUNC_QUERY, 32'sd5, 1'b0);
      queue_item(FUNC_APPEND, 32'sd100, 1'b0);
      queue_item(FUNC_QUERY, 32'sd99, 1'b0);
      queue_item(FUNC_QUERY, 32'sd100, 1'b0);
      queue_item(FUNC_QUERY, S_MIN, 1'b0);
      // unsorted table: answer follows the probe order
      queue_item(FUNC_CLEAR, 32'sd0, 1'b0);
      queue_item(FUNC_APPEND, 32'sd50, 1'b0);
      queue_item(FUNC_APPEND, 32'sd10, 1'b0);
      queue_item(FUNC_APPEND, 32'sd30, 1'b0);
      queue_item(FUNC_QUERY, 32'sd20, 1'b0);

      // random: mostly sorted loads followed by lookups, some unsorted and noise
      base = n_queued;
      while (n_queued - base < 600) begin
         sel = $urandom_range(0, 19);
         if (sel < 14) begin
            step = pick_step();
            queue_item(FUNC_CLEAR, $urandom, $urandom_range(0, 15) == 0);
            queue_ascending(($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 24), step);
            repeat ($urandom_range(2, 12)) queue_item(FUNC_QUERY, pick_key(), 1'b0);
            if ($urandom_range(0, 2) == 0) begin
               queue_ascending($urandom_range(1, 6), step);
               repeat ($urandom_range(1, 6)) queue_item(FUNC_QUERY, pick_key(), 1'b0);
            end
         end else if (sel < 17) begin
            queue_item(FUNC_CLEAR, $urandom, 1'b0);
            repeat ($urandom_range(2, 10)) queue_item(FUNC_APPEND, $urandom, 1'b0);
            repeat ($urandom_range(2, 8)) queue_item(FUNC_QUERY, pick_key(), 1'b0);
         end else begin
            repeat ($urandom_range(1, 8))
               queue_item(FUNC_W'($urandom_range(0, 3)), $urandom, 1'b0);
         end
      end

      // fill the table across the whole value range, then overflow it
      queue_item(FUNC_CLEAR, $urandom, 1'b1);
      queue_item(FUNC_APPEND, S_MIN, 1'b0);
      queue_ascending(DEPTH - 1 + 3, 32'h0080_0000);
      repeat (24) queue_item(FUNC_QUERY, pick_key(), 1'b0);
      queue_item(FUNC_UNUSED, $urandom, 1'b0);
      queue_item(FUNC_QUERY, S_MAX, 1'b0);
      queue_item(FUNC_QUERY, S_MIN, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || outstanding != 0);
      repeat (40) @(posedge clock);

      if (fail_count == 0 && expected_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // driver: bursts with random gaps, held off only for drain points
   always @(posedge clock) begin : drive_proc
      search_req_type it;
      logic           took;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         took = req_valid;
         if (gap_left > 0 && hold_left == 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_reqs[0].drain && (took || outstanding != 0)) begin
            req_valid <= 1'b0;
         end else begin
            it = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_func <= it.func;
            req_operand_value <= it.value;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver: stall pattern changes mode now and then; one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 150) begin
         rsp_stall <= 1'b1;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else begin
         case (rx_mode)
            RX_FLOW:   rsp_stall <= 1'b0;
            RX_SPARSE: rsp_stall <= ($urandom_range(0, 2) == 0);
            RX_TOGGLE: rsp_stall <= ~rsp_stall;
            default:   rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
         if (mode_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(8, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
      end
   end

   // monitor: check results first, then predict the transfer taken at this edge
   always @(posedge clock) begin : check_proc
      res_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: index %0d status %0d",
                           rsp_found_index, rsp_status);
            end else begin
               want = expected_results.pop_front();
               if (rsp_found_index !== want.found_index || rsp_status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: index exp %0d got %0d, status exp %0d got %0d",
                              want.found_index, rsp_found_index, want.status, rsp_status);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(search_result(req_func, req_operand_value));
         outstanding <= expected_results.size();
      end
   end

endmodule
